[rtl/rbsd_pkg.sv]
package rbsd_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int SPAN_COORD_W   = 10;
    localparam int ORIGIN_W       = 10;
    localparam int COLOR_W        = 16;
    localparam int COUNT_W        = 8;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 2'd2;

    localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 16'hFFFF;

    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOI   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    localparam logic KIND_SPAN = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] GRAY_SCALE = 8'd17;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_COUNT  = 3'd1,
        PH_SECOND = 3'd2,
        PH_DX     = 3'd3,
        PH_DY     = 3'd4,
        PH_ABS    = 3'd5,
        PH_PAD    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [COLOR_W-1:0]  background;
    } cfg_t;

    typedef struct packed {
        logic                    emit;
        logic                    kind;
        logic [SPAN_COORD_W-1:0] x;
        logic [SPAN_COORD_W-1:0] y;
        logic [COUNT_W-1:0]      length;
        logic [COLOR_W-1:0]      color_even;
        logic [COLOR_W-1:0]      color_odd;
        logic                    draw_even;
        logic                    draw_odd;
    } result_t;

    function automatic logic [COLOR_W-1:0] gray_to_565(input logic [3:0] g);
        logic [11:0] prod;
        logic [7:0]  v;
        begin
            prod = 12'(g) * 12'(GRAY_SCALE);
            v    = prod[7:0];
            gray_to_565 = {v[7:3], v[7:2], v[7:3]};
        end
    endfunction

endpackage

[rtl/rbsd_parser.sv]
module rbsd_parser #(
    parameter int COORD_BITS = rbsd_pkg::COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       code,
    input  rbsd_pkg::cfg_t   cfg,
    output rbsd_pkg::result_t res
);
    import rbsd_pkg::*;

    localparam int CW = COORD_BITS;

    phase_t              phase_reg, phase_next;
    logic [CW-1:0]       cursor_x_reg, cursor_x_next;
    logic [CW-1:0]       cursor_y_reg, cursor_y_next;
    logic [COUNT_W-1:0]  held_reg, held_next;
    logic [COUNT_W-1:0]  left_reg, left_next;
    logic                pad_reg, pad_next;

    logic [CW+SPAN_COORD_W-1:0] cx_wide;
    logic [CW+SPAN_COORD_W-1:0] cy_wide;
    logic [COLOR_W-1:0]         color_even;
    logic [COLOR_W-1:0]         color_odd;
    logic [8:0]                 code_inc;
    logic [COUNT_W-1:0]         abs_len;

    assign cx_wide    = (CW+SPAN_COORD_W)'(cursor_x_reg);
    assign cy_wide    = (CW+SPAN_COORD_W)'(cursor_y_reg);
    assign color_even = gray_to_565(code[7:4]);
    assign color_odd  = gray_to_565(code[3:0]);
    assign code_inc   = {1'b0, code} + 9'd1;
    assign abs_len    = (left_reg >= 8'd2) ? 8'd2 : 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_SECOND:
            begin
                if (held_reg != '0)
                begin
                    phase_next = PH_COUNT;
                end
                else
                begin
                    case (code)
                        ESC_EOL:   phase_next = PH_COUNT;
                        ESC_EOI:   phase_next = PH_START;
                        ESC_DELTA: phase_next = PH_DX;
                        default:   phase_next = PH_ABS;
                    endcase
                end
            end
            PH_DX:  phase_next = PH_DY;
            PH_DY:  phase_next = PH_COUNT;
            PH_ABS:
            begin
                if (left_reg <= abs_len)
                begin
                    phase_next = pad_reg ? PH_PAD : PH_COUNT;
                end
            end
            PH_PAD: phase_next = PH_COUNT;
            default: phase_next = PH_SECOND;
        endcase
    end

    always_comb
    begin
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        held_next      = held_reg;
        left_next      = left_reg;
        pad_next       = pad_reg;
        res            = '0;
        res.kind       = KIND_SPAN;
        res.x          = cx_wide[SPAN_COORD_W-1:0];
        res.y          = cy_wide[SPAN_COORD_W-1:0];
        res.color_even = color_even;
        res.color_odd  = color_odd;
        res.draw_even  = (color_even != cfg.background);
        res.draw_odd   = (color_odd != cfg.background);
        case (phase_reg)
            PH_SECOND:
            begin
                if (held_reg != '0)
                begin
                    res.emit      = 1'b1;
                    res.length    = held_reg;
                    cursor_x_next = cursor_x_reg + CW'(held_reg);
                end
                else
                begin
                    case (code)
                        ESC_EOL:
                        begin
                            cursor_x_next = CW'(cfg.origin_x);
                            cursor_y_next = cursor_y_reg + CW'(1);
                        end
                        ESC_EOI:
                        begin
                            res      = '0;
                            res.emit = 1'b1;
                            res.kind = KIND_END;
                        end
                        ESC_DELTA: ;
                        default:
                        begin
                            left_next = code;
                            pad_next  = code_inc[1];
                        end
                    endcase
                end
            end
            PH_DX: held_next = code;
            PH_DY:
            begin
                cursor_x_next = cursor_x_reg + CW'(held_reg);
                cursor_y_next = cursor_y_reg + CW'(code);
            end
            PH_ABS:
            begin
                res.emit      = 1'b1;
                res.length    = abs_len;
                cursor_x_next = cursor_x_reg + CW'(abs_len);
                left_next     = (left_reg >= abs_len) ? left_reg - abs_len : '0;
            end
            PH_PAD: pad_next = 1'b0;
            PH_START:
            begin
                cursor_x_next = CW'(cfg.origin_x);
                cursor_y_next = CW'(cfg.origin_y);
                held_next     = code;
            end
            default: held_next = code;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            held_reg     <= '0;
            left_reg     <= '0;
            pad_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            held_reg     <= held_next;
            left_reg     <= left_next;
            pad_reg      <= pad_next;
        end
    end

    a_abs_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ABS |-> left_reg != '0)
        else $error("absolute run entered with no pixels left");

    a_pad_only_when_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_ABS && phase_next == PH_PAD |-> pad_reg)
        else $error("pad phase entered without pending pad");

    a_start_loads_origin: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_START |=> cursor_y_reg == CW'($past(cfg.origin_y)))
        else $error("cursor not loaded from origin at start of image");

endmodule

[rtl/rle4_bitmap_span_decoder.sv]
// An accepted byte is held in the input register; its result, if any, is then registered in the result register.
// Throughput: one byte per cycle; the parser step is a single pass from the
// input register to the result register. While a result waits downstream, bytes
// that yield no result keep flowing; a byte that yields one holds in the input register.
// Reset: asynchronous, active low; origin 0,0, background 0xFFFF, parser at start of image.
module rle4_bitmap_span_decoder #(
    parameter int COORD_BITS = rbsd_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            code_byte,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  kind,
    output logic [rbsd_pkg::SPAN_COORD_W-1:0]     span_x,
    output logic [rbsd_pkg::SPAN_COORD_W-1:0]     span_y,
    output logic [rbsd_pkg::COUNT_W-1:0]          span_length,
    output logic [rbsd_pkg::COLOR_W-1:0]          color_even,
    output logic [rbsd_pkg::COLOR_W-1:0]          color_odd,
    output logic                                  draw_even,
    output logic                                  draw_odd,
    input  logic                                  cfg_write_en,
    input  logic [rbsd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rbsd_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import rbsd_pkg::*;

    cfg_t        cfg_reg;
    logic        full_reg, full_next;
    logic [7:0]  byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    result_t     res;
    logic        out_free;
    logic        advance;
    logic        accept;

    rbsd_parser #(
        .COORD_BITS(COORD_BITS)
    ) u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .code  (byte_reg),
        .cfg   (cfg_reg),
        .res   (res)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = full_reg && (!res.emit || out_free);
    assign in_ready  = !full_reg || advance;
    assign accept    = in_valid && in_ready;

    assign full_next      = accept ? 1'b1 : (advance ? 1'b0 : full_reg);
    assign out_valid_next = (advance && res.emit) ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.background <= BACKGROUND_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:   cfg_reg.origin_x   <= cfg_data[ORIGIN_W-1:0];
                CFG_ORIGIN_Y:   cfg_reg.origin_y   <= cfg_data[ORIGIN_W-1:0];
                CFG_BACKGROUND: cfg_reg.background <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= code_byte;
        end
        if (advance && res.emit)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_reg.kind;
    assign span_x      = out_reg.x;
    assign span_y      = out_reg.y;
    assign span_length = out_reg.length;
    assign color_even  = out_reg.color_even;
    assign color_odd   = out_reg.color_odd;
    assign draw_even   = out_reg.draw_even;
    assign draw_odd    = out_reg.draw_odd;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && res.emit && out_valid_reg && !out_ready |-> !advance)
        else $error("parser advanced while result register was blocked");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> full_reg)
        else $error("accepted item lost from input register");

    a_span_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == KIND_SPAN |-> out_reg.length != '0)
        else $error("span result with zero length");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == KIND_END |->
            out_reg.length == '0 && out_reg.x == '0 && out_reg.color_even == '0)
        else $error("end of image result carries span data");

endmodule
